// ===== src/lat_pkg.sv =====
// lat_pkg: shared types and constants for the launch acceleration timer
// holds payload structs, configuration struct, register indexes and threshold codes
// no dependencies
package lat_pkg;

	localparam int unsigned SPEED_W   = 12;
	localparam int unsigned MS_W      = 16;
	localparam int unsigned STAMP_W   = 32;
	localparam int unsigned WHICH_W   = 2;
	localparam int unsigned APB_AW    = 5;
	localparam int unsigned APB_DW    = 32;
	localparam int unsigned REG_IDX_W = 3;

	// register indexes, byte address is 4 * index
	typedef enum logic [REG_IDX_W-1:0] {
		REG_STOP_SPEED     = 3'd0,
		REG_LOW_THRESHOLD  = 3'd1,
		REG_HIGH_THRESHOLD = 3'd2,
		REG_LOW_MAX_MS     = 3'd3,
		REG_HIGH_MAX_MS    = 3'd4,
		REG_HOLD_MS        = 3'd5
	} reg_idx_t;

	// which threshold a latched figure belongs to
	localparam logic [WHICH_W-1:0] WHICH_NONE = 2'd0;
	localparam logic [WHICH_W-1:0] WHICH_LOW  = 2'd1;
	localparam logic [WHICH_W-1:0] WHICH_HIGH = 2'd2;

	// register reset values
	localparam logic [SPEED_W-1:0] STOP_SPEED_RST     = 12'd10;
	localparam logic [SPEED_W-1:0] LOW_THRESHOLD_RST  = 12'd500;
	localparam logic [SPEED_W-1:0] HIGH_THRESHOLD_RST = 12'd1000;
	localparam logic [MS_W-1:0]    LOW_MAX_MS_RST     = 16'd15000;
	localparam logic [MS_W-1:0]    HIGH_MAX_MS_RST    = 16'd30000;
	localparam logic [MS_W-1:0]    HOLD_MS_RST        = 16'd7000;

	typedef struct packed {
		logic [STAMP_W-1:0] now_ms;
		logic [SPEED_W-1:0] speed_dkph;
		logic               forward_gear;
	} sample_t;

	typedef struct packed {
		logic               display_active;
		logic [WHICH_W-1:0] shown_which;
		logic [MS_W-1:0]    shown_elapsed_ms;
	} result_t;

	typedef struct packed {
		logic [SPEED_W-1:0] stop_speed;
		logic [SPEED_W-1:0] low_threshold;
		logic [SPEED_W-1:0] high_threshold;
		logic [MS_W-1:0]    low_max_ms;
		logic [MS_W-1:0]    high_max_ms;
		logic [MS_W-1:0]    hold_ms;
	} cfg_t;

endpackage

// ===== src/launch_acceleration_timer_unit.sv =====
// launch_acceleration_timer_unit: top level of the launch acceleration timer
// depends on lat_pkg, lat_cfg_regs and lat_core

// Takes one vehicle sample (timestamp, speed in tenths of km/h, drive flag) per transfer
// and returns one result per sample: whether a latched launch time is being shown, for
// which threshold, and the time in milliseconds. A sample is accepted every clock cycle
// while the result side keeps up; each result passes one input register and one result
// register. The figure of one sample per cycle is set by the run-state update in
// lat_core, which reads and writes its state in the same cycle so that each sample sees
// the state left by the one before. Timestamps wrap modulo 2^TIME_BITS. Registers sit at
// byte addresses 4*index; the user must write them only while idle, as the block does not check.
module launch_acceleration_timer_unit #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// sample channel
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  lat_pkg::sample_t           sample,
	// result channel
	output logic                       result_valid,
	input  logic                       result_stall,
	output lat_pkg::result_t           result,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lat_pkg::APB_AW-1:0] paddr,
	input  logic [lat_pkg::APB_DW-1:0] pwdata,
	output logic [lat_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);

	lat_pkg::cfg_t    cfg;
	lat_pkg::sample_t sample_s1;
	lat_pkg::result_t result_s2, core_result;
	logic             valid_s1, valid_s2;
	logic             adv_s1, adv_s2, take_in;

	lat_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// result register frees when empty or when its transfer completes
	assign adv_s2 = !valid_s2 || !result_stall;
	// the input stage moves on into the core whenever the result register can take it
	assign adv_s1 = valid_s1 && adv_s2;
	// input register takes a new sample when empty or emptying this cycle
	assign sample_stall = valid_s1 && !adv_s2;
	assign take_in      = sample_valid && !sample_stall;

	// core state steps exactly once per sample, as it leaves the input register
	lat_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.sample (sample_s1),
		.cfg    (cfg),
		.result (core_result)
	);

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (take_in) begin
			sample_s1 <= sample;
		end
		if (adv_s1) begin
			result_s2 <= core_result;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

// ===== src/lat_cfg_regs.sv =====
// lat_cfg_regs: apb-style register file for the launch acceleration timer
// depends on lat_pkg for register indexes, reset values and cfg_t
module lat_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lat_pkg::APB_AW-1:0] paddr,
	input  logic [lat_pkg::APB_DW-1:0] pwdata,
	output logic [lat_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output lat_pkg::cfg_t              cfg
);

	lat_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [lat_pkg::REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = paddr[lat_pkg::APB_AW-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_speed     <= lat_pkg::STOP_SPEED_RST;
			cfg_q.low_threshold  <= lat_pkg::LOW_THRESHOLD_RST;
			cfg_q.high_threshold <= lat_pkg::HIGH_THRESHOLD_RST;
			cfg_q.low_max_ms     <= lat_pkg::LOW_MAX_MS_RST;
			cfg_q.high_max_ms    <= lat_pkg::HIGH_MAX_MS_RST;
			cfg_q.hold_ms        <= lat_pkg::HOLD_MS_RST;
		end else if (wr_en) begin
			case (idx)
				lat_pkg::REG_STOP_SPEED:     cfg_q.stop_speed     <= pwdata[lat_pkg::SPEED_W-1:0];
				lat_pkg::REG_LOW_THRESHOLD:  cfg_q.low_threshold  <= pwdata[lat_pkg::SPEED_W-1:0];
				lat_pkg::REG_HIGH_THRESHOLD: cfg_q.high_threshold <= pwdata[lat_pkg::SPEED_W-1:0];
				lat_pkg::REG_LOW_MAX_MS:     cfg_q.low_max_ms     <= pwdata[lat_pkg::MS_W-1:0];
				lat_pkg::REG_HIGH_MAX_MS:    cfg_q.high_max_ms    <= pwdata[lat_pkg::MS_W-1:0];
				lat_pkg::REG_HOLD_MS:        cfg_q.hold_ms        <= pwdata[lat_pkg::MS_W-1:0];
				default: ;
			endcase
		end
	end

	// read back, unused indexes read as zero
	always_comb begin
		prdata = '0;
		case (idx)
			lat_pkg::REG_STOP_SPEED:     prdata[lat_pkg::SPEED_W-1:0] = cfg_q.stop_speed;
			lat_pkg::REG_LOW_THRESHOLD:  prdata[lat_pkg::SPEED_W-1:0] = cfg_q.low_threshold;
			lat_pkg::REG_HIGH_THRESHOLD: prdata[lat_pkg::SPEED_W-1:0] = cfg_q.high_threshold;
			lat_pkg::REG_LOW_MAX_MS:     prdata[lat_pkg::MS_W-1:0]    = cfg_q.low_max_ms;
			lat_pkg::REG_HIGH_MAX_MS:    prdata[lat_pkg::MS_W-1:0]    = cfg_q.high_max_ms;
			lat_pkg::REG_HOLD_MS:        prdata[lat_pkg::MS_W-1:0]    = cfg_q.hold_ms;
			default:                     prdata = '0;
		endcase
	end

endmodule

// ===== src/lat_core.sv =====
// lat_core: run state of the launch timer and the per-sample update
// depends on lat_pkg for sample_t, result_t, cfg_t and threshold codes
module lat_core #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  lat_pkg::sample_t sample,
	input  lat_pkg::cfg_t    cfg,
	output lat_pkg::result_t result
);

	logic                        armed_q, running_q, got_low_q, got_high_q;
	logic [TIME_BITS-1:0]        run_start_q, latched_at_q;
	logic [lat_pkg::WHICH_W-1:0] latched_which_q;
	logic [lat_pkg::MS_W-1:0]    latched_elapsed_q;

	logic                        armed_d, running_d, got_low_d, got_high_d;
	logic [TIME_BITS-1:0]        run_start_d, latched_at_d;
	logic [lat_pkg::WHICH_W-1:0] latched_which_d;
	logic [lat_pkg::MS_W-1:0]    latched_elapsed_d;

	logic [63:0]          now_ext, low_cap_ext, high_cap_ext, hold_ext;
	logic [TIME_BITS-1:0] now_w, elapsed, age;
	logic                 latch_now;
	logic                 show;

	// stamps are taken modulo 2^TIME_BITS
	assign now_ext      = {32'b0, sample.now_ms};
	assign low_cap_ext  = {48'b0, cfg.low_max_ms};
	assign high_cap_ext = {48'b0, cfg.high_max_ms};
	assign hold_ext     = {48'b0, cfg.hold_ms};
	assign now_w        = now_ext[TIME_BITS-1:0];
	assign elapsed      = now_w - run_start_q;

	always_comb begin
		armed_d           = armed_q;
		running_d         = running_q;
		got_low_d         = got_low_q;
		got_high_d        = got_high_q;
		run_start_d       = run_start_q;
		latched_which_d   = latched_which_q;
		latched_elapsed_d = latched_elapsed_q;
		latched_at_d      = latched_at_q;
		latch_now         = 1'b0;
		if (sample.speed_dkph < cfg.stop_speed) begin
			running_d  = 1'b0;
			armed_d    = 1'b1;
			got_low_d  = 1'b0;
			got_high_d = 1'b0;
		end else if (!running_q) begin
			if (armed_q && sample.forward_gear) begin
				running_d   = 1'b1;
				armed_d     = 1'b0;
				run_start_d = now_w;
				got_low_d   = 1'b0;
				got_high_d  = 1'b0;
			end
		end else if (!sample.forward_gear) begin
			running_d = 1'b0;
		end else begin
			if (!got_low_q && sample.speed_dkph >= cfg.low_threshold) begin
				got_low_d = 1'b1;
				if (elapsed <= low_cap_ext[TIME_BITS-1:0]) begin
					latched_which_d   = lat_pkg::WHICH_LOW;
					latched_elapsed_d = elapsed[lat_pkg::MS_W-1:0];
					latched_at_d      = now_w;
					latch_now         = 1'b1;
				end
			end
			// high overrides a low latch from the same sample
			if (!got_high_q && sample.speed_dkph >= cfg.high_threshold) begin
				got_high_d = 1'b1;
				running_d  = 1'b0;
				if (elapsed <= high_cap_ext[TIME_BITS-1:0]) begin
					latched_which_d   = lat_pkg::WHICH_HIGH;
					latched_elapsed_d = elapsed[lat_pkg::MS_W-1:0];
					latched_at_d      = now_w;
					latch_now         = 1'b1;
				end
			end
		end
	end

	// a figure latched by this sample has age zero, so it is always in the window
	assign age  = now_w - latched_at_q;
	assign show = (latched_which_d != lat_pkg::WHICH_NONE)
		&& (latch_now || (age <= hold_ext[TIME_BITS-1:0]));

	always_comb begin
		result.display_active   = show;
		result.shown_which      = show ? latched_which_d : lat_pkg::WHICH_NONE;
		result.shown_elapsed_ms = show ? latched_elapsed_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q           <= 1'b0;
			running_q         <= 1'b0;
			got_low_q         <= 1'b0;
			got_high_q        <= 1'b0;
			run_start_q       <= '0;
			latched_which_q   <= lat_pkg::WHICH_NONE;
			latched_elapsed_q <= '0;
			latched_at_q      <= '0;
		end else if (step) begin
			armed_q           <= armed_d;
			running_q         <= running_d;
			got_low_q         <= got_low_d;
			got_high_q        <= got_high_d;
			run_start_q       <= run_start_d;
			latched_which_q   <= latched_which_d;
			latched_elapsed_q <= latched_elapsed_d;
			latched_at_q      <= latched_at_d;
		end
	end

endmodule

// ===== verif/tb_launch_acceleration_timer_unit.sv =====
`timescale 1ns / 1ps
// tb_launch_acceleration_timer_unit: self-checking testbench for the launch acceleration timer
// depends on lat_pkg and launch_acceleration_timer_unit

module tb_launch_acceleration_timer_unit;
	import lat_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 85;

	// run-state model of the block, its register copies and the readouts still owed
	class launch_timer_checker;
		logic [SPEED_W-1:0] stop_speed, low_threshold, high_threshold;
		logic [MS_W-1:0]    low_max_ms, high_max_ms, hold_ms;
		bit                 armed, running, got_low, got_high;
		logic [STAMP_W-1:0] run_start_ms, latched_at_ms;
		logic [WHICH_W-1:0] latched_which;
		logic [MS_W-1:0]    latched_elapsed;
		result_t            pending_readouts[$];
		int                 errors;

		function new();
			stop_speed      = STOP_SPEED_RST;
			low_threshold   = LOW_THRESHOLD_RST;
			high_threshold  = HIGH_THRESHOLD_RST;
			low_max_ms      = LOW_MAX_MS_RST;
			high_max_ms     = HIGH_MAX_MS_RST;
			hold_ms         = HOLD_MS_RST;
			armed           = 1'b0;
			running         = 1'b0;
			got_low         = 1'b0;
			got_high        = 1'b0;
			run_start_ms    = '0;
			latched_at_ms   = '0;
			latched_which   = WHICH_NONE;
			latched_elapsed = '0;
			errors          = 0;
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		function void set_reg(reg_idx_t idx, logic [APB_DW-1:0] v);
			case (idx)
				REG_STOP_SPEED:     stop_speed     = v[SPEED_W-1:0];
				REG_LOW_THRESHOLD:  low_threshold  = v[SPEED_W-1:0];
				REG_HIGH_THRESHOLD: high_threshold = v[SPEED_W-1:0];
				REG_LOW_MAX_MS:     low_max_ms     = v[MS_W-1:0];
				REG_HIGH_MAX_MS:    high_max_ms    = v[MS_W-1:0];
				REG_HOLD_MS:        hold_ms        = v[MS_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [APB_DW-1:0] reg_value(reg_idx_t idx);
			case (idx)
				REG_STOP_SPEED:     return APB_DW'(stop_speed);
				REG_LOW_THRESHOLD:  return APB_DW'(low_threshold);
				REG_HIGH_THRESHOLD: return APB_DW'(high_threshold);
				REG_LOW_MAX_MS:     return APB_DW'(low_max_ms);
				REG_HIGH_MAX_MS:    return APB_DW'(high_max_ms);
				REG_HOLD_MS:        return APB_DW'(hold_ms);
				default:            return '0;
			endcase
		endfunction

		// arm / start / abort / threshold crossing for one sample
		function void advance_run(sample_t s);
			logic [STAMP_W-1:0] elapsed;
			if (s.speed_dkph < stop_speed) begin
				running  = 1'b0;
				armed    = 1'b1;
				got_low  = 1'b0;
				got_high = 1'b0;
				return;
			end
			if (!running) begin
				if (armed && s.forward_gear) begin
					running      = 1'b1;
					armed        = 1'b0;
					run_start_ms = s.now_ms;
					got_low      = 1'b0;
					got_high     = 1'b0;
				end
				return;
			end
			if (!s.forward_gear) begin
				running = 1'b0;
				return;
			end
			elapsed = s.now_ms - run_start_ms;
			if (!got_low && s.speed_dkph >= low_threshold) begin
				got_low = 1'b1;
				if (elapsed <= STAMP_W'(low_max_ms)) begin
					latched_which   = WHICH_LOW;
					latched_elapsed = elapsed[MS_W-1:0];
					latched_at_ms   = s.now_ms;
				end
			end
			// high may overwrite a low latch made by the same sample
			if (!got_high && s.speed_dkph >= high_threshold) begin
				got_high = 1'b1;
				running  = 1'b0;
				if (elapsed <= STAMP_W'(high_max_ms)) begin
					latched_which   = WHICH_HIGH;
					latched_elapsed = elapsed[MS_W-1:0];
					latched_at_ms   = s.now_ms;
				end
			end
		endfunction

		function void note_sample(sample_t s);
			result_t            r;
			logic [STAMP_W-1:0] age;
			advance_run(s);
			r   = '0;
			age = s.now_ms - latched_at_ms;
			if (latched_which != WHICH_NONE && age <= STAMP_W'(hold_ms)) begin
				r.display_active   = 1'b1;
				r.shown_which      = latched_which;
				r.shown_elapsed_ms = latched_elapsed;
			end
			pending_readouts.push_back(r);
		endfunction

		task check_result(result_t got);
			result_t want;
			if (pending_readouts.size() == 0) begin
				report("result transfer with nothing outstanding");
				return;
			end
			want = pending_readouts.pop_front();
			if (got.display_active !== want.display_active)
				report($sformatf("display_active %0b, want %0b",
					got.display_active, want.display_active));
			if (got.shown_which !== want.shown_which)
				report($sformatf("shown_which %0d, want %0d",
					got.shown_which, want.shown_which));
			if (got.shown_elapsed_ms !== want.shown_elapsed_ms)
				report($sformatf("shown_elapsed_ms %0d, want %0d",
					got.shown_elapsed_ms, want.shown_elapsed_ms));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               sample_valid;
	logic               sample_stall;
	sample_t            sample;
	logic               result_valid;
	logic               result_stall = 1'b0;
	result_t            result;
	logic               psel, penable, pwrite;
	logic [APB_AW-1:0]  paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	launch_timer_checker sb;
	int                  send_idle_pct;
	int                  stall_pct;
	int                  cycle_count = 0;
	int                  items_sent;
	logic [STAMP_W-1:0]  clock_ms;

	launch_acceleration_timer_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on a cycle count
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// both channels are looked at on the rising edge, before the block's flops move
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall)
				sb.note_sample(sample);
			if (result_valid && !result_stall)
				sb.check_result(result);
		end
	end

	// receiver back-pressure, redrawn on every falling edge
	always @(negedge clk) begin
		result_stall = ($urandom_range(0, 99) < stall_pct);
	end

	// one sample transfer, with random sender gaps in front of it
	task automatic send_sample(input sample_t s);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_valid = 1'b0;
			@(negedge clk);
		end
		sample_valid = 1'b1;
		sample       = s;
		do @(posedge clk); while (sample_stall);
		@(negedge clk);
		sample_valid = 1'b0;
		items_sent++;
	endtask

	task automatic push_at(input logic [STAMP_W-1:0] t, input int spd, input bit gear);
		sample_t s;
		clock_ms       = t;
		s.now_ms       = t;
		s.speed_dkph   = SPEED_W'(spd);
		s.forward_gear = gear;
		send_sample(s);
	endtask

	task automatic push_step(input int spd, input bit gear, input int step);
		push_at(clock_ms + STAMP_W'(step), spd, gear);
	endtask

	// apb write followed by a read-back of the same register
	task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] v);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, v);
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== sb.reg_value(idx))
			sb.report($sformatf("register %s reads %0h, want %0h",
				idx.name(), prdata, sb.reg_value(idx)));
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// let every owed readout arrive, then let the two-stage pipe drain
	task automatic wait_idle();
		while (sb.pending_readouts.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apply_settings(input int stop, input int low, input int high,
		input int low_max, input int high_max, input int hold);
		write_reg(REG_STOP_SPEED, APB_DW'(stop));
		write_reg(REG_LOW_THRESHOLD, APB_DW'(low));
		write_reg(REG_HIGH_THRESHOLD, APB_DW'(high));
		write_reg(REG_LOW_MAX_MS, APB_DW'(low_max));
		write_reg(REG_HIGH_MAX_MS, APB_DW'(high_max));
		write_reg(REG_HOLD_MS, APB_DW'(hold));
	endtask

	// hand-picked walk through arming, runs, latching, hold expiry and wrap
	task automatic directed_launches();
		push_at(32'd100, 4095, 1'b1);    // moving before ever stopping: no run
		push_at(32'd200, 0, 1'b0);       // stopped: arms
		push_at(32'd300, 20, 1'b0);      // moving out of drive: no start
		push_at(32'd1000, 20, 1'b1);     // run starts
		push_at(32'd5000, 500, 1'b1);    // low latched at 4000
		push_at(32'd9000, 1000, 1'b1);   // high latched at 8000, run over
		push_at(32'd16000, 1000, 1'b1);  // last ms of the hold window
		push_at(32'd16001, 1000, 1'b1);  // window just gone
		push_at(32'd16100, 0, 1'b1);
		push_at(32'd16200, 50, 1'b1);
		push_at(32'd16300, 3000, 1'b1);  // both thresholds at once, high wins
		push_at(32'd16400, 5, 1'b1);     // re-arm while still shown
		push_at(32'd20000, 50, 1'b1);
		push_at(32'd35001, 600, 1'b1);   // low one ms over its cap
		push_at(32'd35100, 700, 1'b0);   // leaving drive aborts
		push_at(32'd35200, 1200, 1'b1);  // disarmed: nothing happens
		push_at(32'd35300, 0, 1'b1);
		push_at(32'hFFFF_F000, 100, 1'b1); // start just below the wrap
		push_at(32'h0000_0800, 600, 1'b1); // low across the wrap
		push_at(32'h0000_1000, 2000, 1'b1);
		push_at(32'h0000_2000, 0, 1'b1);
		push_at(32'h0000_3000, 50, 1'b1);
		push_at(32'h0000_33E8, 600, 1'b1);  // low at 1000
		push_at(32'h0000_3000 + 32'd30001, 1100, 1'b1); // high over cap, low kept
		push_at(32'h0000_3000 + 32'd30006, 4095, 1'b1);
	endtask

	// stop, launch in drive, ramp past the thresholds, then linger in the hold window
	task automatic random_launch();
		int stop, target, cap, n, spd;
		stop   = int'(sb.stop_speed);
		target = (sb.low_threshold > sb.high_threshold) ? int'(sb.low_threshold)
			: int'(sb.high_threshold);
		target = target + $urandom_range(0, 200);
		if (target > 4095)
			target = 4095;
		if (target < stop)
			target = stop;
		cap = (sb.low_max_ms > sb.high_max_ms) ? int'(sb.low_max_ms) : int'(sb.high_max_ms);
		repeat ($urandom_range(1, 3))
			push_step((stop == 0) ? 0 : $urandom_range(0, stop - 1),
				1'($urandom_range(0, 1)), $urandom_range(0, 3000));
		if ($urandom_range(0, 4) == 0)
			push_step($urandom_range(stop, 4095), 1'b0, $urandom_range(0, 500));
		push_step($urandom_range(stop, (stop + 50 > 4095) ? 4095 : stop + 50), 1'b1,
			$urandom_range(0, 3000));
		n = $urandom_range(1, 8);
		for (int k = 1; k <= n; k++) begin
			spd = stop + (target - stop) * k / n;
			push_step(spd, ($urandom_range(0, 19) != 0), $urandom_range(0, cap * 5 / (4 * n) + 1));
		end
		repeat ($urandom_range(1, 4)) begin
			if ($urandom_range(0, 2) == 0)
				// right at the edge of the hold window
				push_at(sb.latched_at_ms + STAMP_W'(sb.hold_ms) + STAMP_W'($urandom_range(0, 1)),
					$urandom_range(0, 4095), 1'($urandom_range(0, 1)));
			else
				push_step($urandom_range(0, 4095), 1'($urandom_range(0, 1)),
					$urandom_range(0, sb.hold_ms + sb.hold_ms / 4 + 2));
		end
	endtask

	initial begin
		int goal;
		sb            = new();
		arst_n        = 1'b0;
		sample_valid  = 1'b0;
		sample        = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		items_sent    = 0;
		clock_ms      = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_launches();

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: ;  // keep the reset settings
				1: apply_settings(0, 0, 0, 0, 0, 0);
				2: apply_settings(4095, 4095, 4095, 65535, 65535, 65535);
				default: apply_settings($urandom_range(0, 300), $urandom_range(0, 3000),
					$urandom_range(0, 4095), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 20000));
			endcase
			// rotate through the idling patterns
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 70; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 70; end
				default: begin send_idle_pct = 6; stall_pct = 6; end
			endcase
			clock_ms = $urandom;
			goal     = items_sent + ITEMS_PER_PHASE;
			while (items_sent < goal) begin
				if ($urandom_range(0, 4) != 0)
					random_launch();
				else
					// free noise across every bit of the sample
					push_at($urandom, $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
			end
		end

		wait_idle();
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
